### rtl/brlsu_pkg.sv
`default_nettype none
package brlsu_pkg;

    // byte memory geometry, split into byte lanes so one access across the lanes covers any 8-byte span
    localparam int MEM_BYTES = 4096;
    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int NUM_LANES = 8;
    localparam int LANE_W    = $clog2(NUM_LANES);
    localparam int ROWS      = MEM_BYTES / NUM_LANES;
    localparam int ROW_W     = $clog2(ROWS);

    localparam int NUM_REGIONS   = 2;
    localparam bit NATIVE_LITTLE = 1'b1;

    // base + offset, offset known to fit 13 bits once the range check passes
    localparam int SUM_W = (ADDR_W > 14) ? ADDR_W : 14;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream widths
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_R0_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_R0_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_R0_WR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_SIZE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_R1_WR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND    = 3'd6;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [1:0] ORDER_LITTLE = 2'd0;
    localparam logic [1:0] ORDER_NATIVE = 2'd2;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_UNBOUND    = 3'd1,
        ST_READ_ONLY  = 3'd2,
        ST_RANGE      = 3'd3,
        ST_MISALIGNED = 3'd4
    } t_status;

    // classified access, as queued for the back end
    typedef struct packed {
        logic              cmd;
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [1:0]        width_code;
        logic              little;
        logic              sext;
        logic [63:0]       data;
    } t_op;

endpackage
`default_nettype wire

### rtl/bounded_region_load_store_unit.sv
`default_nettype none
// Bounds-checked load/store unit over a 4096-byte memory with two configurable
// regions. Each access is checked (region bound, writable for stores, offset plus
// width inside the region, base plus offset against the alignment mask) and then
// loads or stores 1, 2, 4 or 8 bytes in little or big endian order; a failed check
// returns its status code with data 0 and leaves memory untouched. The memory is
// eight byte-wide lanes of 512 rows, so any access, aligned or not, touches each
// lane at most once and completes in a single memory access: the unit sustains one
// transfer per clock when nothing stalls, and m_axis_tvalid rises once the input
// transfer has passed the queue, the memory read and the output register. A two-entry
// queue between the checking front end and the memory back end lets either side
// stall alone. After reset the memory is zeroed one row per cycle, all 512 rows,
// during which s_axis_tready stays low; config writes are taken at any time but
// must only be issued while the unit is idle.
module bounded_region_load_store_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // config write port
    input  wire logic                               i_cfg_we,
    input  wire logic [brlsu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [brlsu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // access stream
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // region_index[1:0], width_code[3:2], alignment[10:4], endian[12:11],
    // sext[13], offset[77:14], store_data[141:78], zero pad[143:142]
    input  wire logic [brlsu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // cmd[0]
    input  wire logic                               s_axis_tuser,
    // result stream
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // data[63:0]
    output logic [brlsu_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // status[2:0]
    output logic [2:0]                              m_axis_tuser
);
    import brlsu_pkg::*;

    logic w_push, w_pop, w_full, w_empty, w_mem_ready;
    t_op  w_in_op, w_head_op;

    // front end: config registers, checks, classification
    brlsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_q_full    (w_full),
        .i_mem_ready (w_mem_ready),
        .o_push      (w_push),
        .o_op        (w_in_op)
    );

    brlsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_in_op),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_op    (w_head_op)
    );

    // back end: lane memories, clear pass, load assembly, output register
    brlsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_op        (w_head_op),
        .o_pop       (w_pop),
        .o_mem_ready (w_mem_ready),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_status    (m_axis_tuser),
        .o_data      (m_axis_tdata)
    );
endmodule
`default_nettype wire

### rtl/brlsu_ram.sv
`default_nettype none
module brlsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end
endmodule
`default_nettype wire

### rtl/brlsu_front.sv
`default_nettype none
module brlsu_front (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [brlsu_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [brlsu_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [brlsu_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  wire logic                               i_tuser,
    input  wire logic                               i_q_full,
    input  wire logic                               i_mem_ready,
    output logic                                    o_push,
    output brlsu_pkg::t_op                          o_op
);
    import brlsu_pkg::*;

    logic [11:0] r_base0, r_base1;
    logic [12:0] r_size0, r_size1;
    logic        r_wr0, r_wr1;
    logic [1:0]  r_bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base0 <= '0;
            r_size0 <= '0;
            r_wr0   <= 1'b0;
            r_base1 <= '0;
            r_size1 <= '0;
            r_wr1   <= 1'b0;
            r_bound <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_R0_BASE: r_base0 <= i_cfg_data[11:0];
                CFG_R0_SIZE: r_size0 <= i_cfg_data[12:0];
                CFG_R0_WR:   r_wr0   <= i_cfg_data[0];
                CFG_R1_BASE: r_base1 <= i_cfg_data[11:0];
                CFG_R1_SIZE: r_size1 <= i_cfg_data[12:0];
                CFG_R1_WR:   r_wr1   <= i_cfg_data[0];
                CFG_BOUND:   r_bound <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // field slices of the input word
    logic [1:0]  w_region, w_wc, w_order;
    logic [6:0]  w_align, w_mask;
    logic        w_sext;
    logic [63:0] w_offset, w_sdata;

    assign w_region = i_tdata[1:0];
    assign w_wc     = i_tdata[3:2];
    assign w_align  = i_tdata[10:4];
    assign w_order  = i_tdata[12:11];
    assign w_sext   = i_tdata[13];
    assign w_offset = i_tdata[77:14];
    assign w_sdata  = i_tdata[141:78];

    logic [1:0]       w_bound;
    logic [11:0]      w_base;
    logic [12:0]      w_size;
    logic             w_wr;
    logic [3:0]       w_nbytes;
    logic [13:0]      w_end;
    logic [SUM_W-1:0] w_sum;
    t_status          w_status;

    assign w_bound  = (r_bound > 2'(NUM_REGIONS)) ? 2'(NUM_REGIONS) : r_bound;
    assign w_base   = w_region[0] ? r_base1 : r_base0;
    assign w_size   = w_region[0] ? r_size1 : r_size0;
    assign w_wr     = w_region[0] ? r_wr1 : r_wr0;
    assign w_nbytes = 4'd1 << w_wc;
    assign w_end    = 14'(w_offset[12:0]) + 14'(w_nbytes);
    assign w_sum    = SUM_W'(w_base) + SUM_W'(w_offset[12:0]);
    assign w_mask   = w_align - 7'd1;

    // checks in priority order
    always_comb begin
        if (w_region >= w_bound) begin
            w_status = ST_UNBOUND;
        end else if (i_tuser == CMD_STORE && !w_wr) begin
            w_status = ST_READ_ONLY;
        end else if ((|w_offset[63:13]) || (w_end > 14'(w_size))) begin
            w_status = ST_RANGE;
        end else if (w_align == 7'd0 || (w_sum[6:0] & w_mask) != 7'd0) begin
            w_status = ST_MISALIGNED;
        end else begin
            w_status = ST_OK;
        end
    end

    assign o_ready = i_mem_ready && !i_q_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_op.cmd        = i_tuser;
        o_op.status     = w_status;
        o_op.addr       = w_sum[ADDR_W-1:0];
        o_op.width_code = w_wc;
        o_op.little     = (w_order == ORDER_LITTLE) ||
                          (w_order == ORDER_NATIVE && NATIVE_LITTLE);
        o_op.sext       = w_sext;
        o_op.data       = w_sdata;
    end
endmodule
`default_nettype wire

### rtl/brlsu_queue.sv
`default_nettype none
module brlsu_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  brlsu_pkg::t_op      i_op,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output brlsu_pkg::t_op      o_op
);
    import brlsu_pkg::*;

    t_op               r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_pop) |-> !i_push)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count out of range");
endmodule
`default_nettype wire

### rtl/brlsu_back.sv
`default_nettype none
module brlsu_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_empty,
    input  brlsu_pkg::t_op                          i_op,
    output logic                                    o_pop,
    output logic                                    o_mem_ready,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [2:0]                              o_status,
    output logic [brlsu_pkg::OUT_TDATA_W-1:0]       o_data
);
    import brlsu_pkg::*;

    typedef enum logic {S_CLEAR, S_RUN} t_state;

    t_state             r_state;
    logic [ROW_W-1:0]   r_clr_row;

    logic               r_s1_valid;
    logic               r_s1_cmd;
    t_status            r_s1_status;
    logic [LANE_W-1:0]  r_s1_rot;
    logic [1:0]         r_s1_wc;
    logic               r_s1_little;
    logic               r_s1_sext;
    logic [63:0]        r_s1_data;

    logic               r_out_valid;
    logic [2:0]         r_out_status;
    logic [63:0]        r_out_data;

    logic               w_s1_move;
    logic [3:0]         w_nbytes;
    logic [LANE_W-1:0]  w_rot;
    logic [ROW_W-1:0]   w_row;

    logic [NUM_LANES-1:0] w_en;
    logic                 w_we;
    logic [ROW_W-1:0]     w_addr  [NUM_LANES];
    logic [7:0]           w_wdata [NUM_LANES];
    logic [7:0]           w_rdata [NUM_LANES];

    assign w_s1_move   = r_s1_valid && (!r_out_valid || i_ready);
    assign o_pop       = (r_state == S_RUN) && !i_empty && (!r_s1_valid || w_s1_move);
    assign o_mem_ready = (r_state == S_RUN);
    assign w_nbytes    = 4'd1 << i_op.width_code;
    assign w_rot       = i_op.addr[LANE_W-1:0];
    assign w_row       = i_op.addr[ADDR_W-1:LANE_W];
    assign w_we        = (r_state == S_CLEAR) || (i_op.cmd == CMD_STORE);

    // lane b holds access byte i = b - rot; lanes below rot wrap into the next row
    always_comb begin
        logic [LANE_W-1:0] idx, sh;
        for (int b = 0; b < NUM_LANES; b++) begin
            idx = LANE_W'(b) - w_rot;
            sh  = i_op.little ? idx : (LANE_W'(w_nbytes - 4'd1) - idx);
            if (r_state == S_CLEAR) begin
                w_en[b]    = 1'b1;
                w_addr[b]  = r_clr_row;
                w_wdata[b] = 8'h00;
            end else begin
                w_en[b]    = o_pop && (i_op.status == ST_OK) &&
                             ({1'b0, idx} < w_nbytes);
                w_addr[b]  = w_row + ROW_W'(LANE_W'(b) < w_rot);
                w_wdata[b] = i_op.data[8*sh +: 8];
            end
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        brlsu_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
            .i_clk   (i_clk),
            .i_en    (w_en[g]),
            .i_we    (w_we),
            .i_addr  (w_addr[g]),
            .i_wdata (w_wdata[g]),
            .o_rdata (w_rdata[g])
        );
    end

    // load assembly from the lane read data
    logic [3:0]  w_s1_nb;
    logic [63:0] w_bits, w_load, w_result;

    assign w_s1_nb = 4'd1 << r_s1_wc;

    always_comb begin
        logic [LANE_W-1:0] src;
        for (int j = 0; j < NUM_LANES; j++) begin
            src = r_s1_little ? LANE_W'(j) : (LANE_W'(w_s1_nb - 4'd1) - LANE_W'(j));
            w_bits[8*j +: 8] = (4'(j) < w_s1_nb) ? w_rdata[LANE_W'(r_s1_rot + src)] : 8'h00;
        end
    end

    always_comb begin
        w_load = w_bits;
        if (r_s1_sext) begin
            case (r_s1_wc)
                2'd0: w_load = {{56{w_bits[7]}},  w_bits[7:0]};
                2'd1: w_load = {{48{w_bits[15]}}, w_bits[15:0]};
                2'd2: w_load = {{32{w_bits[31]}}, w_bits[31:0]};
                default: w_load = w_bits;
            endcase
        end
    end

    always_comb begin
        if (r_s1_status != ST_OK) begin
            w_result = '0;
        end else if (r_s1_cmd == CMD_STORE) begin
            w_result = r_s1_data;
        end else begin
            w_result = w_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + 1'b1;
                    if (r_clr_row == ROW_W'(ROWS - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: ;
                default: r_state <= S_CLEAR;
            endcase
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_cmd    <= i_op.cmd;
            r_s1_status <= i_op.status;
            r_s1_rot    <= w_rot;
            r_s1_wc     <= i_op.width_code;
            r_s1_little <= i_op.little;
            r_s1_sext   <= i_op.sext;
            r_s1_data   <= i_op.data;
        end
        if (w_s1_move) begin
            r_out_status <= r_s1_status;
            r_out_data   <= w_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_data   = r_out_data;

    a_clear_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_pop)
        else $error("access issued during memory clear");
    a_fail_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !(o_pop && i_op.status == ST_OK)) |-> (w_en == '0))
        else $error("memory touched by a failed or absent access");
    a_pop_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped access lost");
endmodule
`default_nettype wire

### verif/tb_bounded_region_load_store_unit.sv
`default_nettype none
module tb_bounded_region_load_store_unit;
    import brlsu_pkg::*;

    // byte order code 1 is big endian, and code 3 is decoded the same way
    localparam logic [1:0] ORDER_BIG     = 2'd1;
    localparam logic [1:0] ORDER_BIG_ALT = 2'd3;

    // access size codes
    localparam logic [1:0] W1 = 2'd0;
    localparam logic [1:0] W2 = 2'd1;
    localparam logic [1:0] W4 = 2'd2;
    localparam logic [1:0] W8 = 2'd3;

    // The watchdog budget covers the clear after reset, the longest sender gap and
    // the longest sink stall back to back, several times over.
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int PHASE_ITEMS     = 60;

    typedef struct {
        logic        cmd;
        logic [1:0]  region;
        logic [1:0]  wcode;
        logic [6:0]  align;
        logic [1:0]  order;
        logic        sext;
        logic [63:0] offset;
        logic [63:0] wdata;
    } t_access;

    typedef struct {
        t_status     status;
        logic [63:0] data;
    } t_outcome;

    // one row of the directed table: a register write or an access
    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        t_access               acc;
        bit                    known;   // exp holds a hand-written outcome
        t_outcome              exp;
    } t_step;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [2:0]             m_axis_tuser;

    bounded_region_load_store_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // shadow copy of the memory and the region registers, all zero at reset
    bit [7:0]  shadow_mem  [MEM_BYTES];
    bit [11:0] region_base [NUM_REGIONS];
    bit [12:0] region_size [NUM_REGIONS];
    bit        region_wr   [NUM_REGIONS];
    bit [1:0]  bound_regs;

    t_outcome  pending_results[$];
    t_step     directed_steps[$];
    int        mismatches  = 0;
    bit        calm        = 1'b0;  // no gaps or stalls on either side
    int        stall_left  = 0;
    int        idle_cycles = 0;

    // Works out the outcome of one access and applies a store to the shadow
    // memory. Checks go in order: bound, writable, range, alignment.
    function automatic t_outcome predict_access(t_access a);
        t_outcome          r;
        int unsigned       width;
        int unsigned       sh;
        logic [1:0]        live;
        logic [11:0]       base;
        logic [ADDR_W-1:0] idx;
        logic [12:0]       size;
        logic              wr;
        logic [63:0]       addr;
        logic [63:0]       bits;
        bit                little;

        r.status = ST_OK;
        r.data   = '0;
        bits     = '0;
        live = (bound_regs > 2'(NUM_REGIONS)) ? 2'(NUM_REGIONS) : bound_regs;
        if (a.region >= live) begin
            r.status = ST_UNBOUND;
            return r;
        end
        base = region_base[a.region[0]];
        size = region_size[a.region[0]];
        wr   = region_wr[a.region[0]];
        if (a.cmd == CMD_STORE && !wr) begin
            r.status = ST_READ_ONLY;
            return r;
        end
        width = 32'd1 << a.wcode;
        if (width > size || a.offset > 64'(size) - 64'(width)) begin
            r.status = ST_RANGE;
            return r;
        end
        addr = 64'(base) + a.offset;
        // non power-of-two alignments use align-1 as a plain mask
        if (a.align == 7'd0 || (addr & (64'(a.align) - 64'd1)) != 64'd0) begin
            r.status = ST_MISALIGNED;
            return r;
        end
        little = (a.order == ORDER_LITTLE) || (a.order == ORDER_NATIVE && NATIVE_LITTLE);
        for (int unsigned i = 0; i < width; i++) begin
            sh  = little ? i : width - 1 - i;
            idx = addr[ADDR_W-1:0] + ADDR_W'(i);   // wraps past the top of memory
            if (a.cmd == CMD_STORE)
                shadow_mem[idx] = a.wdata[sh*8 +: 8];
            else
                bits[sh*8 +: 8] = shadow_mem[idx];
        end
        if (a.cmd == CMD_STORE) begin
            r.data = a.wdata;
        end else begin
            // sign extension only matters below 8 bytes
            if (a.sext && width < 8 && bits[width*8-1])
                bits = bits | ~((64'd1 << (width*8)) - 64'd1);
            r.data = bits;
        end
        return r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 85)
            return int'($urandom_range(1, 3));
        else if (roll < 97)
            return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    function automatic t_access mk(logic cmd, logic [1:0] region, logic [1:0] wcode,
                                   logic [6:0] align, logic [1:0] order, logic sext,
                                   logic [63:0] offset, logic [63:0] wdata);
        t_access a;
        a.cmd    = cmd;
        a.region = region;
        a.wcode  = wcode;
        a.align  = align;
        a.order  = order;
        a.sext   = sext;
        a.offset = offset;
        a.wdata  = wdata;
        return a;
    endfunction

    function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_step s;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        s.known  = 1'b0;
        directed_steps.push_back(s);
    endfunction

    function automatic void add_access(t_access a, bit known, t_status st, logic [63:0] d);
        t_step s;
        s.is_cfg     = 1'b0;
        s.acc        = a;
        s.known      = known;
        s.exp.status = st;
        s.exp.data   = d;
        directed_steps.push_back(s);
    endfunction

    // Mostly well-formed accesses to bound regions: in range and aligned.
    // The rest goes past the end, uses odd alignments, or is pure noise.
    function automatic t_access random_access();
        t_access     a;
        int unsigned width;
        int unsigned size;
        int unsigned off;
        int unsigned mis;
        int unsigned roll;
        logic [11:0] base;

        a.cmd    = 1'($urandom_range(0, 1));
        a.region = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(2, 3))
                                               : 2'($urandom_range(0, 1));
        a.wcode  = 2'($urandom_range(0, 3));
        a.order  = 2'($urandom_range(0, 3));
        a.sext   = 1'($urandom_range(0, 1));
        a.wdata  = {$urandom, $urandom};
        a.align  = 7'(1 << $urandom_range(0, int'(a.wcode)));
        base  = region_base[a.region[0]];
        size  = region_size[a.region[0]];
        width = 32'd1 << a.wcode;
        roll  = $urandom_range(0, 99);
        if (roll < 8) begin
            a.align  = 7'($urandom_range(0, 64));
            a.offset = {$urandom, $urandom};
        end else if (size < width) begin
            a.offset = 64'($urandom_range(0, 16));
        end else begin
            off = $urandom_range(0, size - width);
            if (roll < 18) begin
                a.align = 7'($urandom_range(0, 64));
            end else if (roll < 24) begin
                off = size - width + $urandom_range(1, 4);
            end else begin
                // pull the offset down so base + offset lands on the boundary
                mis = (int'(base) + off) & (int'(a.align) - 1);
                if (mis <= off)
                    off = off - mis;
            end
            a.offset = 64'(off);
        end
        return a;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    // one register write, shadow registers follow at the same edge
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_R0_BASE: region_base[0] = val[11:0];
            CFG_R0_SIZE: region_size[0] = val[12:0];
            CFG_R0_WR:   region_wr[0]   = val[0];
            CFG_R1_BASE: region_base[1] = val[11:0];
            CFG_R1_SIZE: region_size[1] = val[12:0];
            CFG_R1_WR:   region_wr[1]   = val[0];
            CFG_BOUND:   bound_regs     = val[1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // sender holds off until every outstanding result is back, then settles
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Offers one access and waits for its transfer; tvalid stays high after
    // the transfer so back-to-back accesses need no extra edge.
    task automatic send_access(t_access a, bit known, t_outcome listed);
        int       gap;
        t_outcome predicted;

        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= a.cmd;
        s_axis_tdata  <= {2'b00, a.wdata, a.offset, a.sext, a.order, a.align,
                          a.wcode, a.region};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        // the predictor always runs so that stores reach the shadow memory
        predicted = predict_access(a);
        pending_results.push_back(known ? listed : predicted);
    endtask

    // New random region layout; bases and sizes lean toward the extremes.
    task automatic randomize_regions();
        logic [CFG_DATA_W-1:0] base;
        logic [CFG_DATA_W-1:0] size;
        int unsigned           roll;

        for (int r = 0; r < NUM_REGIONS; r++) begin
            case ($urandom_range(0, 3))
                0:       base = 13'd0;
                1:       base = 13'd4095;
                default: base = 13'($urandom_range(0, 4095));
            endcase
            case ($urandom_range(0, 5))
                0:       size = 13'd0;
                1:       size = 13'd8;
                2:       size = 13'd64;
                3:       size = 13'd256;
                4:       size = 13'd4096;
                default: size = 13'($urandom_range(0, 4096));
            endcase
            write_reg((r == 0) ? CFG_R0_BASE : CFG_R1_BASE, base);
            write_reg((r == 0) ? CFG_R0_SIZE : CFG_R1_SIZE, size);
            write_reg((r == 0) ? CFG_R0_WR : CFG_R1_WR,
                      13'($urandom_range(0, 3) != 0));
        end
        roll = $urandom_range(0, 9);
        write_reg(CFG_BOUND, (roll == 0) ? 13'd0 : (roll == 1) ? 13'd1 :
                             (roll == 2) ? 13'd3 : 13'd2);
    endtask

    // Result side: compare every transfer with the oldest pending outcome.
    always @(posedge i_clk) begin : result_check
        t_outcome exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d data %h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                exp = pending_results.pop_front();
                if (m_axis_tuser != exp.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              m_axis_tuser, exp.status));
                if (m_axis_tdata != exp.data)
                    report_mismatch($sformatf("data %h, want %h",
                                              m_axis_tdata, exp.data));
            end
        end
    end

    // Sink backpressure: ready most cycles, stalls of random length otherwise.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (calm || $urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall_left    <= pick_gap() - 1;
        end
    end

    // Watchdog: any transfer on either stream restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("[bounded_region_load_store_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_outcome none;

        none.status = ST_OK;
        none.data   = '0;

        // --- directed table ---
        // nothing bound yet
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd1, ORDER_LITTLE, 1'b0, 64'd0, 64'd0),
                   1, ST_UNBOUND, 64'd0);
        add_access(mk(CMD_STORE, 2'd3, W8, 7'd1, ORDER_LITTLE, 1'b0, 64'd0, '1),
                   1, ST_UNBOUND, 64'd0);
        // region 0 covers all memory; region 1 starts at the top byte and is
        // read-only; bound count 3 is clamped to two regions
        add_cfg(CFG_R0_BASE, 13'd0);
        add_cfg(CFG_R0_SIZE, 13'd4096);
        add_cfg(CFG_R0_WR,   13'd1);
        add_cfg(CFG_R1_BASE, 13'd4095);
        add_cfg(CFG_R1_SIZE, 13'd16);
        add_cfg(CFG_R1_WR,   13'd0);
        add_cfg(CFG_BOUND,   13'd3);
        // memory is clear after reset
        add_access(mk(CMD_LOAD, 2'd0, W8, 7'd8, ORDER_LITTLE, 1'b0, 64'd0, 64'd0),
                   1, ST_OK, 64'd0);
        add_access(mk(CMD_STORE, 2'd0, W8, 7'd1, ORDER_LITTLE, 1'b0, 64'd0,
                      64'h8877_6655_4433_2211), 1, ST_OK, 64'h8877_6655_4433_2211);
        // read back in every byte order, with and without sign extension
        add_access(mk(CMD_LOAD, 2'd0, W8, 7'd8, ORDER_BIG, 1'b0, 64'd0, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd1, ORDER_LITTLE, 1'b1, 64'd7, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W2, 7'd2, ORDER_BIG_ALT, 1'b1, 64'd6, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W4, 7'd4, ORDER_NATIVE, 1'b1, 64'd4, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W8, 7'd8, ORDER_LITTLE, 1'b1, 64'd0, 64'd0),
                   0, ST_OK, 64'd0);
        // the read-only, range and alignment checks failing
        add_access(mk(CMD_STORE, 2'd1, W1, 7'd1, ORDER_LITTLE, 1'b0, 64'd0, '1),
                   1, ST_READ_ONLY, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W2, 7'd1, ORDER_LITTLE, 1'b0, 64'd4095, 64'd0),
                   1, ST_RANGE, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd1, ORDER_LITTLE, 1'b0, '1, 64'd0),
                   1, ST_RANGE, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd0, ORDER_LITTLE, 1'b0, 64'd0, 64'd0),
                   1, ST_MISALIGNED, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W2, 7'd2, ORDER_LITTLE, 1'b0, 64'd1, 64'd0),
                   1, ST_MISALIGNED, 64'd0);
        // alignment 3 acts as mask 2
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd3, ORDER_LITTLE, 1'b0, 64'd3, 64'd0),
                   1, ST_MISALIGNED, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd3, ORDER_LITTLE, 1'b0, 64'd4, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W8, 7'd64, ORDER_LITTLE, 1'b0, 64'd64, 64'd0),
                   0, ST_OK, 64'd0);
        // top of memory, then region 1 reads that wrap around to address 0
        add_access(mk(CMD_STORE, 2'd0, W8, 7'd8, ORDER_BIG, 1'b0, 64'd4088, '1),
                   1, ST_OK, '1);
        add_access(mk(CMD_LOAD, 2'd1, W8, 7'd1, ORDER_LITTLE, 1'b0, 64'd0, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd1, W8, 7'd1, ORDER_BIG, 1'b0, 64'd8, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd1, W8, 7'd1, ORDER_LITTLE, 1'b0, 64'd9, 64'd0),
                   1, ST_RANGE, 64'd0);
        // only region 0 bound
        add_cfg(CFG_R1_WR, 13'd1);
        add_cfg(CFG_BOUND, 13'd1);
        add_access(mk(CMD_LOAD, 2'd1, W1, 7'd1, ORDER_LITTLE, 1'b0, 64'd0, 64'd0),
                   1, ST_UNBOUND, 64'd0);
        // wrapping store through region 1, read back through region 0
        add_cfg(CFG_BOUND, 13'd2);
        add_access(mk(CMD_STORE, 2'd1, W8, 7'd1, ORDER_BIG, 1'b0, 64'd0,
                      64'h0123_4567_89ab_cdef), 1, ST_OK, 64'h0123_4567_89ab_cdef);
        add_access(mk(CMD_LOAD, 2'd0, W8, 7'd8, ORDER_LITTLE, 1'b0, 64'd4088, 64'd0),
                   0, ST_OK, 64'd0);
        add_access(mk(CMD_LOAD, 2'd0, W4, 7'd4, ORDER_BIG, 1'b1, 64'd0, 64'd0),
                   0, ST_OK, 64'd0);
        // empty region: every access is out of range
        add_cfg(CFG_R0_SIZE, 13'd0);
        add_access(mk(CMD_LOAD, 2'd0, W1, 7'd1, ORDER_LITTLE, 1'b0, 64'd0, 64'd0),
                   1, ST_RANGE, 64'd0);

        // reset once; the unit then clears its memory before taking transfers
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                wait_drained();
                write_reg(directed_steps[k].idx, directed_steps[k].val);
            end else begin
                send_access(directed_steps[k].acc, directed_steps[k].known,
                            directed_steps[k].exp);
            end
        end

        // --- random phases, each with a fresh region layout ---
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            randomize_regions();
            calm = (phase == 3);   // one phase runs at full rate
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_access(random_access(), 1'b0, none);
        end
        calm = 1'b0;
        wait_drained();

        if (mismatches == 0)
            $display("[bounded_region_load_store_unit] OK");
        else
            $display("[bounded_region_load_store_unit] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
